/* design/cle_pkg.sv */
// Shared constants, state encoding and result word type for the console line editor.
package cle_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic DEST_ECHO = 1'b0;
  localparam logic DEST_PROG = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE,
    S_ECR,
    S_ELF,
    S_FLUSH,
    S_FCR,
    S_FLF,
    S_BS1,
    S_SP,
    S_BS2
  } state_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

endpackage

/* design/cle_if.sv */
// Valid/ready channel interfaces for raw console bytes and result words.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic       dest;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output dest, output out_byte, output last, input ready);
  modport sink (input valid, input dest, input out_byte, input last, output ready);
endinterface

/* design/cle_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/cle_obuf.sv */
// Output register stage that holds one result word until the sink takes it.
module cle_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cle_pkg::result_t  res,
  output logic              can_push,
  cle_out_if.source         tx
);
  import cle_pkg::*;

  logic    full;
  result_t hold;

  assign can_push = !full || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (tx.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= res;
    end
  end

  assign tx.valid = full;
  assign tx.dest = hold.dest;
  assign tx.out_byte = hold.out_byte;
  assign tx.last = hold.last;

endmodule

/* design/console_line_editor_top.sv */
// Cooked-mode console line editor. One raw byte is taken on rx when the block is idle; it
// gives zero to LINE_CAPACITY+4 result words on tx, one per cycle while tx is ready, with
// last set on the final word of each byte. A printable byte, erase or forwarded control
// is accepted in S_IDLE and then gives its words; a line end streams the line buffer RAM
// one entry per cycle while the output register can take a word. A one-word output
// register lets the next word be produced while the previous one waits.
module console_line_editor_top (
  input  logic      clk,
  input  logic      rst,
  cle_in_if.sink    rx,
  cle_out_if.source tx
);
  import cle_pkg::*;

  state_t            state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              after_cr, after_cr_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [7:0]        cur, cur_next;
  logic              cur_dest, cur_dest_next;

  logic              we;
  logic [7:0]        rd_data;
  logic              push;
  logic              can_push;
  result_t           res;
  logic [7:0]        c;
  logic              printable;
  logic [LEN_W-1:0]  idx_inc;

  assign c = rx.rx_byte;
  assign printable = (c >= CH_SP && c <= CH_TILDE) || c == CH_TAB;
  assign idx_inc = LEN_W'(idx) + LEN_W'(1);
  assign rx.ready = (state == S_IDLE);

  // read address tracks idx_next so rd_data always holds the entry at idx
  cle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (len[ADDR_W-1:0]),
    .wdata (c),
    .raddr (idx_next),
    .rdata (rd_data)
  );

  cle_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .can_push (can_push),
    .tx       (tx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len <= '0;
      after_cr <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      len <= len_next;
      after_cr <= after_cr_next;
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    cur_dest <= cur_dest_next;
  end

  always_comb begin
    state_next = state;
    len_next = len;
    after_cr_next = after_cr;
    idx_next = idx;
    cur_next = cur;
    cur_dest_next = cur_dest;
    we = 1'b0;
    push = 1'b0;
    res = '{dest: DEST_ECHO, out_byte: CH_CR, last: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (rx.valid) begin
          if (c == CH_LF && after_cr) begin
            after_cr_next = 1'b0;
          end else begin
            after_cr_next = (c == CH_CR);
            if (c == CH_LF || c == CH_CR) begin
              idx_next = '0;
              state_next = S_ECR;
            end else if (c == CH_DEL || c == CH_BS) begin
              if (len != '0) begin
                len_next = len - LEN_W'(1);
                state_next = S_BS1;
              end
            end else if (c == CH_ETX) begin
              len_next = '0;
              cur_next = c;
              cur_dest_next = DEST_PROG;
              state_next = S_ONE;
            end else if (printable) begin
              if (len < LEN_W'(LINE_CAPACITY)) begin
                we = 1'b1;
                len_next = len + LEN_W'(1);
                cur_next = c;
                cur_dest_next = DEST_ECHO;
                state_next = S_ONE;
              end
            end else begin
              cur_next = c;
              cur_dest_next = DEST_PROG;
              state_next = S_ONE;
            end
          end
        end
      end
      S_ONE: begin
        res = '{dest: cur_dest, out_byte: cur, last: 1'b1};
        if (can_push) begin
          push = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ECR: begin
        res = '{dest: DEST_ECHO, out_byte: CH_CR, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          state_next = S_ELF;
        end
      end
      S_ELF: begin
        res = '{dest: DEST_ECHO, out_byte: CH_LF, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          state_next = (len == '0) ? S_FCR : S_FLUSH;
        end
      end
      S_FLUSH: begin
        res = '{dest: DEST_PROG, out_byte: rd_data, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          idx_next = idx_inc[ADDR_W-1:0];
          if (idx_inc == len) begin
            state_next = S_FCR;
          end
        end
      end
      S_FCR: begin
        res = '{dest: DEST_PROG, out_byte: CH_CR, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          state_next = S_FLF;
        end
      end
      S_FLF: begin
        res = '{dest: DEST_PROG, out_byte: CH_LF, last: 1'b1};
        if (can_push) begin
          push = 1'b1;
          len_next = '0;
          state_next = S_IDLE;
        end
      end
      S_BS1: begin
        res = '{dest: DEST_ECHO, out_byte: CH_BS, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          state_next = S_SP;
        end
      end
      S_SP: begin
        res = '{dest: DEST_ECHO, out_byte: CH_SP, last: 1'b0};
        if (can_push) begin
          push = 1'b1;
          state_next = S_BS2;
        end
      end
      S_BS2: begin
        res = '{dest: DEST_ECHO, out_byte: CH_BS, last: 1'b1};
        if (can_push) begin
          push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(LINE_CAPACITY))
    else $error("line length above capacity");

  a_flush_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> LEN_W'(idx) < len)
    else $error("flush index past line end");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    push && res.last |=> state == S_IDLE)
    else $error("final word pushed but editor not idle");

  a_eol_start: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready && c == CH_CR |=> state == S_ECR)
    else $error("carriage return did not start line flush");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("word pushed into full output register");

endmodule
